### hdl/fccm_pkg.sv
// shared types, constants and helpers for the fat16 cluster chain manager
// no dependencies
`timescale 1ns / 1ps

package fccm_pkg;

	// table geometry
	localparam int MAX_CLUSTERS = 4096;
	localparam int ADDR_W       = $clog2(MAX_CLUSTERS);
	localparam int LIM_W        = 13;
	localparam int ENTRY_W      = 16;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// special entry values
	localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;
	localparam logic [ENTRY_W-1:0] ENTRY_BAD  = 16'hFFF7;
	localparam logic [ENTRY_W-1:0] ENTRY_EOC  = 16'hFFF8;
	localparam logic [ENTRY_W-1:0] ENTRY_LAST = 16'hFFFF;

	// cluster number limit register
	localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;
	localparam logic [LIM_W-1:0] LIMIT_MAX   = 13'd4096;
	localparam logic [LIM_W-1:0] FIRST_DATA  = 13'd2;

	typedef enum logic [1:0] {
		CMD_NEXT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_SET   = 2'd2,
		CMD_FREE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_END     = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// source of the cluster_out field
	typedef enum logic [1:0] {
		OUT_ZERO = 2'd0,
		OUT_DATA = 2'd1,
		OUT_PTR  = 2'd2
	} out_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     clr_wr;
		logic     rd_cur;
		logic     rd_ptr;
		logic     ptr_inc;
		logic     wr_set;
		logic     wr_alloc;
		logic     wr_free;
		logic     finish;
		status_t  fin_status;
		out_sel_t fin_sel;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_done;
		logic cur_valid;
		logic ptr_at_lim;
		logic steps_at_lim;
		logic data_zero;
		logic data_end;
		logic data_ok;
	} dp_sts_t;

	// data cluster number check: 2 <= c < lim
	function automatic logic is_valid(input logic [ENTRY_W-1:0] c,
	                                  input logic [LIM_W-1:0] lim);
		logic [ENTRY_W-1:0] lim_ext;
		lim_ext = ENTRY_W'(lim);
		return (c >= ENTRY_W'(FIRST_DATA)) && (c < lim_ext);
	endfunction

endpackage

### hdl/fat16_cluster_chain_manager.sv
// fat16 allocation table manager: one result beat (done) per accepted command.
// alloc probes entries first-fit from cluster 2 and free walks the chain link by link; each probe
// or link reads the table, and a hit or a freed link also writes it, on the one table port.
// busy drops in the cycle done shows, so the next command may be taken then; no stall input.
// reset: limit register back to 4096, then a clearing pass that zeroes every table entry, busy high.
`timescale 1ns / 1ps

module fat16_cluster_chain_manager import fccm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [ENTRY_W-1:0] cluster,
	input  logic [ENTRY_W-1:0] entry_value,
	output logic               done,
	output logic [1:0]         status,
	output logic [ENTRY_W-1:0] cluster_out,
	output logic [LIM_W-1:0]   freed_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	dp_cmd_t          dp_cmd;
	dp_sts_t          dp_sts;
	logic [LIM_W-1:0] limit_cfg;

	// configuration registers
	fccm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.limit_cfg (limit_cfg)
	);

	// sequencer
	fccm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.cmd     (dp_cmd),
		.sts     (dp_sts)
	);

	// table and result datapath
	fccm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.limit_cfg   (limit_cfg),
		.cluster     (cluster),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.cluster_out (cluster_out),
		.freed_count (freed_count)
	);

endmodule

### hdl/fccm_regs.sv
// apb configuration register block (cluster number limit)
// depends on fccm_pkg
`timescale 1ns / 1ps

module fccm_regs import fccm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [LIM_W-1:0]   limit_cfg
);

	logic             sel_limit;
	logic [LIM_W-1:0] limit_q;

	// register 0 answers wherever the top address bit is clear
	assign sel_limit = (paddr[PADDR_W-1] == 1'b0);
	assign pready    = 1'b1;

	// write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[LIM_W-1:0];
		end
	end

	// read data
	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = PDATA_W'(limit_q);
		end
	end

	assign limit_cfg = limit_q;

endmodule

### hdl/fccm_datapath.sv
// datapath: allocation table memory, cursor, scan pointer, step count, result register
// depends on fccm_pkg; driven by fccm_ctrl
`timescale 1ns / 1ps

module fccm_datapath import fccm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [LIM_W-1:0]   limit_cfg,
	input  logic [ENTRY_W-1:0] cluster,
	input  logic [ENTRY_W-1:0] entry_value,
	output logic               done,
	output logic [1:0]         status,
	output logic [ENTRY_W-1:0] cluster_out,
	output logic [LIM_W-1:0]   freed_count
);

	logic [ENTRY_W-1:0] mem [MAX_CLUSTERS];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [ENTRY_W-1:0] cur_q;
	logic [ENTRY_W-1:0] val_q;
	logic [LIM_W-1:0]   ptr_q;
	logic [LIM_W-1:0]   cnt_q;
	logic [LIM_W-1:0]   cnt_nxt;
	logic [LIM_W-1:0]   lim;
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic [ENTRY_W-1:0] mem_wd;
	logic               done_q;
	status_t            status_q;
	logic [ENTRY_W-1:0] cluster_out_q;
	logic [LIM_W-1:0]   freed_q;

	// effective limit, clamped to the table size
	assign lim = (limit_cfg > LIMIT_MAX) ? LIMIT_MAX : limit_cfg;

	// memory port selection
	always_comb begin
		if (cmd.clr_wr) begin
			mem_addr = clr_q;
		end else if (cmd.rd_ptr || cmd.wr_alloc) begin
			mem_addr = ptr_q[ADDR_W-1:0];
		end else begin
			mem_addr = cur_q[ADDR_W-1:0];
		end
		mem_we = cmd.clr_wr | cmd.wr_set | cmd.wr_alloc | cmd.wr_free;
		mem_re = cmd.rd_cur | cmd.rd_ptr;
		if (cmd.wr_set) begin
			mem_wd = val_q;
		end else if (cmd.wr_alloc) begin
			mem_wd = ENTRY_LAST;
		end else begin
			mem_wd = ENTRY_FREE;
		end
	end

	// allocation table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign cnt_nxt = cmd.wr_free ? (cnt_q + 1'b1) : cnt_q;

	// command operands, scan pointer and chain step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			val_q <= '0;
			ptr_q <= FIRST_DATA;
			cnt_q <= '0;
		end else if (cmd.load) begin
			cur_q <= cluster;
			val_q <= entry_value;
			ptr_q <= FIRST_DATA;
			cnt_q <= '0;
		end else begin
			if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.wr_free) begin
				cur_q <= rd_data_q;
				cnt_q <= cnt_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			freed_q  <= cnt_nxt;
			case (cmd.fin_sel)
				OUT_DATA: cluster_out_q <= rd_data_q;
				OUT_PTR:  cluster_out_q <= ENTRY_W'(ptr_q);
				default:  cluster_out_q <= '0;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign cluster_out = cluster_out_q;
	assign freed_count = freed_q;

	// status towards the controller
	always_comb begin
		sts.clear_done   = (clr_q == {ADDR_W{1'b1}});
		sts.cur_valid    = is_valid(cur_q, lim);
		sts.ptr_at_lim   = (ptr_q >= lim);
		sts.steps_at_lim = (cnt_q >= lim);
		sts.data_zero    = (rd_data_q == ENTRY_FREE);
		sts.data_end     = (rd_data_q >= ENTRY_EOC);
		sts.data_ok      = is_valid(rd_data_q, lim) && (rd_data_q != ENTRY_BAD);
	end

endmodule

### hdl/fccm_ctrl.sv
// controller state machine: sequences table clear, lookup, set, alloc scan and chain free
// depends on fccm_pkg; drives fccm_datapath
`timescale 1ns / 1ps

module fccm_ctrl import fccm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	output logic       busy,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_NEXT    = 9'b000000100,
		S_NEXT_W  = 9'b000001000,
		S_SET     = 9'b000010000,
		S_ALLOC   = 9'b000100000,
		S_ALLOC_W = 9'b001000000,
		S_FREE    = 9'b010000000,
		S_FREE_W  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.fin_status = ST_OK;
		cmd.fin_sel    = OUT_ZERO;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clear_done) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (cmd_t'(command))
						CMD_NEXT:  state_nxt = S_NEXT;
						CMD_ALLOC: state_nxt = S_ALLOC;
						CMD_SET:   state_nxt = S_SET;
						default:   state_nxt = S_FREE;
					endcase
				end
			end
			S_NEXT: begin
				if (!sts.cur_valid) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_INVALID;
					state_nxt      = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_nxt  = S_NEXT_W;
				end
			end
			S_NEXT_W: begin
				cmd.finish = 1'b1;
				state_nxt  = S_IDLE;
				if (sts.data_end) begin
					cmd.fin_status = ST_END;
				end else if (!sts.data_ok) begin
					cmd.fin_status = ST_INVALID;
				end else begin
					cmd.fin_sel = OUT_DATA;
				end
			end
			S_SET: begin
				cmd.finish = 1'b1;
				state_nxt  = S_IDLE;
				if (sts.cur_valid) begin
					cmd.wr_set = 1'b1;
				end else begin
					cmd.fin_status = ST_INVALID;
				end
			end
			// first-fit scan: read an entry, take it if free, else step the pointer
			S_ALLOC: begin
				if (sts.ptr_at_lim) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_FULL;
					state_nxt      = S_IDLE;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_nxt  = S_ALLOC_W;
				end
			end
			S_ALLOC_W: begin
				if (sts.data_zero) begin
					cmd.wr_alloc = 1'b1;
					cmd.finish   = 1'b1;
					cmd.fin_sel  = OUT_PTR;
					state_nxt    = S_IDLE;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_nxt   = S_ALLOC;
				end
			end
			// chain walk: read link, zero entry, follow old link
			S_FREE: begin
				if (!sts.cur_valid || sts.steps_at_lim) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_INVALID;
					state_nxt      = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_nxt  = S_FREE_W;
				end
			end
			S_FREE_W: begin
				cmd.wr_free = 1'b1;
				if (sts.data_end) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end else begin
					state_nxt = S_FREE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### tb/testbench.sv
// testbench for fat16_cluster_chain_manager: directed, limit-extreme and random chain traffic
// checked beat by beat against a table model kept alongside the block
// depends on hdl/fccm_pkg.sv and hdl/fat16_cluster_chain_manager.sv
`timescale 1ns / 1ps

module testbench;
	import fccm_pkg::*;

	localparam int unsigned ITEMS_TOTAL  = 1800;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned MAX_REPORTS  = 50;
	localparam logic [PADDR_W-1:0] ADDR_LIMIT_REG = '0;

	// expected answer for one command
	typedef struct {
		int unsigned        seq;
		status_t            st;
		logic [ENTRY_W-1:0] clus;
		logic [LIM_W-1:0]   freed;
	} fat_result_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [1:0]         command     = '0;
	logic [ENTRY_W-1:0] cluster     = '0;
	logic [ENTRY_W-1:0] entry_value = '0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [PADDR_W-1:0] paddr       = '0;
	logic [PDATA_W-1:0] pwdata      = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [ENTRY_W-1:0] cluster_out;
	logic [LIM_W-1:0]   freed_count;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// model state: allocation table and limit register
	logic [ENTRY_W-1:0] fat_tbl [MAX_CLUSTERS] = '{default: '0};
	logic [LIM_W-1:0]   limit_reg = LIMIT_RESET;

	fat_result_t pending_results [$];
	fat_result_t last_result;
	int unsigned n_sent   = 0;
	int unsigned n_errors = 0;
	bit          no_gaps  = 1'b0;

	fat16_cluster_chain_manager u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.cluster     (cluster),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.cluster_out (cluster_out),
		.freed_count (freed_count),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit, far beyond every command taking its longest scan
	initial begin
		#1_000_000_000;
		$display("[fat16_cluster_chain_manager] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	// limit as the table sees it, clamped to the table size
	function automatic int unsigned lim_eff();
		return (limit_reg > LIMIT_MAX) ? MAX_CLUSTERS : int'(limit_reg);
	endfunction

	function automatic bit is_data_cluster(input int unsigned c);
		return (c >= FIRST_DATA) && (c < lim_eff());
	endfunction

	// table model: works out one answer and updates the table
	function automatic fat_result_t fat_chain_predict(input cmd_t cmd,
	                                                  input logic [ENTRY_W-1:0] cl,
	                                                  input logic [ENTRY_W-1:0] val);
		fat_result_t r;
		int unsigned lim;
		int unsigned cur;
		int unsigned steps;
		int unsigned freed;
		logic [ENTRY_W-1:0] nxt;
		r.seq   = 0;
		r.st    = ST_OK;
		r.clus  = '0;
		r.freed = '0;
		lim     = lim_eff();
		freed   = 0;
		case (cmd)
			CMD_NEXT: begin
				if (!is_data_cluster(cl)) begin
					r.st = ST_INVALID;
				end else begin
					nxt = fat_tbl[cl];
					if (nxt >= ENTRY_EOC)
						r.st = ST_END;
					else if (!is_data_cluster(nxt) || nxt == ENTRY_BAD)
						r.st = ST_INVALID;
					else
						r.clus = nxt;
				end
			end
			CMD_ALLOC: begin
				// first fit from the first data cluster
				r.st = ST_FULL;
				for (int unsigned c = FIRST_DATA; c < lim; c++) begin
					if (fat_tbl[c] == ENTRY_FREE) begin
						fat_tbl[c] = ENTRY_LAST;
						r.st   = ST_OK;
						r.clus = ENTRY_W'(c);
						break;
					end
				end
			end
			CMD_SET: begin
				if (is_data_cluster(cl))
					fat_tbl[cl] = val;
				else
					r.st = ST_INVALID;
			end
			default: begin
				// free walk: zero the link, then follow its old value
				r.st  = ST_INVALID;
				cur   = cl;
				steps = 0;
				while (is_data_cluster(cur) && steps < lim) begin
					nxt = fat_tbl[cur];
					steps++;
					fat_tbl[cur] = ENTRY_FREE;
					freed++;
					if (nxt >= ENTRY_EOC) begin
						r.st = ST_OK;
						break;
					end
					if (!is_data_cluster(nxt))
						break;
					cur = nxt;
				end
			end
		endcase
		r.freed = LIM_W'(freed);
		return r;
	endfunction

	// one command beat: optional gap, then hold start until the block takes it
	task automatic send_cmd(input cmd_t cmd, input logic [ENTRY_W-1:0] cl,
	                        input logic [ENTRY_W-1:0] val);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		cluster     <= cl;
		entry_value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		last_result     = fat_chain_predict(cmd, cl, val);
		last_result.seq = n_sent;
		n_sent++;
		pending_results.push_back(last_result);
	endtask

	// stop sending and wait for every outstanding answer
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// limit register write while idle; upper data bits carry noise
	task automatic write_limit(input logic [LIM_W-1:0] lim);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LIMIT_REG;
		pwdata  <= {(PDATA_W-LIM_W)'($urandom()), lim};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		limit_reg = lim;
	endtask

	// result beat check against the oldest expectation
	always @(posedge clk) begin : result_check
		fat_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no command outstanding");
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st)
					report_mismatch($sformatf("cmd %0d status %0d, expected %0d",
						exp_r.seq, status, exp_r.st));
				if (cluster_out !== exp_r.clus)
					report_mismatch($sformatf("cmd %0d cluster_out %0h, expected %0h",
						exp_r.seq, cluster_out, exp_r.clus));
				if (freed_count !== exp_r.freed)
					report_mismatch($sformatf("cmd %0d freed_count %0d, expected %0d",
						exp_r.seq, freed_count, exp_r.freed));
			end
		end
	end

	function automatic logic [ENTRY_W-1:0] pick_cluster();
		case ($urandom_range(0, 7))
			0:       return ENTRY_W'($urandom());
			1:       return ENTRY_W'($urandom_range(0, 1));
			default: return ENTRY_W'($urandom_range(0, lim_eff() + 1));
		endcase
	endfunction

	function automatic logic [ENTRY_W-1:0] pick_entry();
		case ($urandom_range(0, 7))
			0:       return ENTRY_FREE;
			1:       return ENTRY_BAD;
			2:       return ENTRY_W'($urandom_range(ENTRY_EOC, ENTRY_LAST));
			3:       return ENTRY_W'($urandom());
			default: return ENTRY_W'($urandom_range(0, lim_eff() + 1));
		endcase
	endfunction

	// every command and its corner cases at the reset limit
	task automatic test_directed_commands();
		send_cmd(CMD_NEXT, 16'h0000, 16'h0000);   // below the data range
		send_cmd(CMD_NEXT, 16'hFFFF, 16'hFFFF);   // top of the field
		send_cmd(CMD_NEXT, 16'd4095, 16'h0000);   // free entry
		send_cmd(CMD_ALLOC, 16'hFFFF, 16'hFFFF);  // empty table gives cluster 2
		send_cmd(CMD_NEXT, 16'd2, 16'h0000);      // end of chain
		send_cmd(CMD_SET, 16'd3, 16'd4);
		send_cmd(CMD_SET, 16'd4, ENTRY_EOC);
		send_cmd(CMD_NEXT, 16'd3, 16'h0000);      // good link
		send_cmd(CMD_SET, 16'd5, ENTRY_BAD);
		send_cmd(CMD_NEXT, 16'd5, 16'h0000);      // bad cluster mark
		send_cmd(CMD_SET, 16'd4096, 16'd1);       // index past the limit
		send_cmd(CMD_SET, 16'd6, 16'd7);
		send_cmd(CMD_SET, 16'd7, 16'd6);          // loop of two
		send_cmd(CMD_FREE, 16'd3, 16'h0000);      // clean two-link chain
		send_cmd(CMD_FREE, 16'd6, 16'h0000);      // loop stops on its own zeroed link
		send_cmd(CMD_FREE, 16'd5, 16'h0000);      // bad link
		send_cmd(CMD_FREE, 16'd1, 16'h0000);      // invalid head frees nothing
		send_cmd(CMD_SET, 16'd4095, ENTRY_LAST);
		send_cmd(CMD_FREE, 16'd4095, 16'h0000);   // last cluster of the table
	endtask

	// limit register extremes: one cluster, none, clamped above the table
	task automatic test_limit_extremes();
		write_limit(13'd3);
		send_cmd(CMD_ALLOC, 16'h0000, 16'h0000);  // cluster 2 still taken: full
		send_cmd(CMD_FREE, 16'd2, 16'h0000);
		send_cmd(CMD_ALLOC, 16'h0000, 16'h0000);
		send_cmd(CMD_NEXT, 16'd3, 16'h0000);      // equal to the limit
		write_limit(13'd0);
		send_cmd(CMD_ALLOC, 16'h0000, 16'h0000);
		send_cmd(CMD_SET, 16'd2, 16'h0000);
		send_cmd(CMD_FREE, 16'd2, 16'h0000);
		write_limit(13'd2);
		send_cmd(CMD_NEXT, 16'd2, 16'h0000);
		write_limit(13'h1FFF);
		send_cmd(CMD_SET, 16'd4095, 16'hFFF9);
		send_cmd(CMD_NEXT, 16'd4095, 16'h0000);
		send_cmd(CMD_ALLOC, 16'h0000, 16'h0000);
		write_limit(LIMIT_RESET);
	endtask

	// allocate a chain, link it, walk it, free it; now and then one link is broken
	task automatic run_chain();
		logic [ENTRY_W-1:0] links [$];
		int unsigned len;
		int unsigned broken;
		int unsigned head;
		len = $urandom_range(1, 6);
		repeat (len) begin
			send_cmd(CMD_ALLOC, pick_cluster(), ENTRY_W'($urandom()));
			if (last_result.st == ST_OK)
				links.push_back(last_result.clus);
		end
		if (links.size() == 0)
			return;
		broken = ($urandom_range(0, 5) == 0) ? $urandom_range(0, links.size() - 1)
		                                     : links.size();
		for (int unsigned i = 0; i < links.size(); i++) begin
			if (i == broken)
				send_cmd(CMD_SET, links[i], pick_entry());
			else if (i + 1 < links.size())
				send_cmd(CMD_SET, links[i], links[i+1]);
			else
				send_cmd(CMD_SET, links[i],
					ENTRY_W'($urandom_range(ENTRY_EOC, ENTRY_LAST)));
		end
		for (int unsigned i = 0; i < links.size(); i++)
			if ($urandom_range(0, 1) == 1)
				send_cmd(CMD_NEXT, links[i], ENTRY_W'($urandom()));
		// mostly from the head; a free from the middle is followed by the head
		head = ($urandom_range(0, 3) == 0) ? $urandom_range(0, links.size() - 1) : 0;
		send_cmd(CMD_FREE, links[head], ENTRY_W'($urandom()));
		if (head != 0)
			send_cmd(CMD_FREE, links[0], ENTRY_W'($urandom()));
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 4))
			send_cmd(cmd_t'($urandom_range(0, 3)), pick_cluster(), pick_entry());
	endtask

	// phases with random limits, mostly small so scans stay short
	task automatic test_random_traffic();
		int unsigned sel;
		logic [LIM_W-1:0] lim;
		while (n_sent < ITEMS_TOTAL) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				case ($urandom_range(0, 4))
					0:       lim = 13'd0;
					1:       lim = 13'd2;
					2:       lim = LIMIT_MAX;
					3:       lim = 13'h1FFF;
					default: lim = LIM_W'($urandom_range(4097, 8191));
				endcase
			end else if (sel < 4) begin
				lim = LIM_W'($urandom_range(65, 600));
			end else begin
				lim = LIM_W'($urandom_range(3, 64));
			end
			write_limit(lim);
			no_gaps = ($urandom_range(0, 2) == 0);
			repeat (6) begin
				if ($urandom_range(0, 3) != 0)
					run_chain();
				else
					run_noise();
				// hold off until the block has answered everything
				if ($urandom_range(0, 9) == 0)
					wait_idle();
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_commands();
		test_limit_extremes();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("[fat16_cluster_chain_manager] OK");
		else
			$display("[fat16_cluster_chain_manager] ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/fccm_pkg.sv
hdl/fccm_regs.sv
hdl/fccm_datapath.sv
hdl/fccm_ctrl.sv
hdl/fat16_cluster_chain_manager.sv
tb/testbench.sv
